### rtl/core/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg: link heartbeat supervisor shared definitions
// Field widths, payload structs, link modes, event codes, controller states
// and the control/status bundles of the serial divider.
// ----------------------------------------------------------------------------
package lhs_pkg;

    localparam int TIME_WIDTH    = 32;
    localparam int COUNT_WIDTH   = 8;
    localparam int DIV_CNT_WIDTH = $clog2(TIME_WIDTH + 1);

    // Largest missed-period count
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration register indexes (paddr[2])
    localparam logic REG_PERIOD    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [31:0] PERIOD_RESET    = 32'd100;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd3;

    // Item kinds
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic [1:0] {
        MODE_WAITING   = 2'd0,
        MODE_CONNECTED = 2'd1,
        MODE_DEGRADED  = 2'd2,
        MODE_LOST      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_RESTORED = 2'd1,
        EV_LOST     = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic                  func;
        logic [TIME_WIDTH-1:0] now_ms;
    } in_t;

    typedef struct packed {
        mode_t                  link_state;
        logic                   commands_allowed;
        event_t                 event_code;
        logic [TIME_WIDTH-1:0]  event_time_ms;
        logic [COUNT_WIDTH-1:0] missed_count;
    } out_t;

    typedef struct packed {
        logic                  start;
        logic [TIME_WIDTH-1:0] dividend;
        logic [TIME_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [TIME_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/core/lhs_div.sv
// ----------------------------------------------------------------------------
// lhs_div: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per busy cycle and one
// quotient bit into quo_reg; a zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module lhs_div
    import lhs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [TIME_WIDTH-1:0]    rem_reg, rem_next;
    logic [TIME_WIDTH-1:0]    quo_reg, quo_next;
    logic [TIME_WIDTH-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [TIME_WIDTH:0]      trial;
    logic [TIME_WIDTH:0]      diff;
    logic                     qbit;

    // Trial subtract of the divisor from the shifted remainder
    assign trial = {rem_reg, quo_reg[TIME_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    // Load on start, advance one quotient bit per busy cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_WIDTH'(TIME_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
            quo_next = {quo_reg[TIME_WIDTH-2:0], qbit};
            cnt_next = cnt_reg - DIV_CNT_WIDTH'(1);
            if (cnt_reg == DIV_CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // A new division never starts on top of a running one
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    // Done follows the last busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a preceding busy cycle");

    // Busy always has a nonzero remaining bit count
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty bit count");

endmodule

### rtl/core/link_heartbeat_supervisor_top.sv
// ----------------------------------------------------------------------------
// link_heartbeat_supervisor_top: link-loss timeout watchdog
// Tracks a link through waiting, connected, degraded and lost from frame
// events and supervision ticks, and reports restore and loss events.
//
//  Channel   Signals                              Transfer when
//  --------  -----------------------------------  ---------------------------
//  input     in_valid, in_stall, in_data          in_valid && !in_stall
//  output    out_valid, out_stall, out_data       out_valid && !out_stall
//  config    psel, penable, pwrite, paddr, ...    psel && penable && pwrite
//
//  A frame, or a tick that is ignored, goes from ST_IDLE straight to ST_WB.
//  An evaluated tick first waits in ST_DIV while the serial divider forms elapsed
//  time / period one quotient bit at a time, then is written back in ST_WB.
//  One item is in work at a time; a finished result waits in the output
//  register while the next item is accepted.
//  Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module link_heartbeat_supervisor_top
    import lhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [TIME_WIDTH-1:0]  last_reg, last_next;
    logic [COUNT_WIDTH-1:0] missed_reg, missed_next;
    logic                   seen_reg, seen_next;
    logic [TIME_WIDTH-1:0]  now_reg, now_next;
    out_t                   res_reg, res_next;
    out_t                   out_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            period_reg;
    logic [7:0]             thresh_reg;

    logic                   in_xfer;
    logic                   eval_tick;
    logic                   out_load;
    logic                   cfg_wr;
    logic [COUNT_WIDTH-1:0] missed_sat;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    lhs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_xfer   = in_valid && !in_stall;
    assign eval_tick = (in_data.func == FUNC_TICK) && seen_reg && (mode_reg != MODE_LOST);

    // Start the divider on the wrapped time since the last frame
    assign div_req.start    = in_xfer && eval_tick;
    assign div_req.dividend = in_data.now_ms - last_reg;
    assign div_req.divisor  = period_reg;

    // Clamp the quotient to the count range
    assign missed_sat = (|div_rsp.quotient[TIME_WIDTH-1:COUNT_WIDTH]) ? COUNT_MAX
                        : div_rsp.quotient[COUNT_WIDTH-1:0];

    // Next controller state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = eval_tick ? ST_DIV : ST_WB;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_DIV:  in_stall = 1'b1;
            ST_WB:   out_load = !out_valid_reg || !out_stall;
            default: in_stall = 1'b1;
        endcase
    end

    // Update link state and form the pending result
    always_comb
    begin
        mode_next   = mode_reg;
        last_next   = last_reg;
        missed_next = missed_reg;
        seen_next   = seen_reg;
        now_next    = now_reg;
        res_next    = res_reg;
        if (in_xfer && !eval_tick)
        begin
            res_next.event_code    = EV_NONE;
            res_next.event_time_ms = '0;
            if (in_data.func == FUNC_FRAME)
            begin
                mode_next   = MODE_CONNECTED;
                last_next   = in_data.now_ms;
                missed_next = '0;
                seen_next   = 1'b1;
                res_next.link_state       = MODE_CONNECTED;
                res_next.commands_allowed = 1'b1;
                res_next.missed_count     = '0;
                if (mode_reg == MODE_LOST)
                begin
                    res_next.event_code    = EV_RESTORED;
                    res_next.event_time_ms = in_data.now_ms;
                end
            end
            else
            begin
                res_next.link_state       = mode_reg;
                res_next.commands_allowed = (mode_reg == MODE_CONNECTED);
                res_next.missed_count     = missed_reg;
            end
        end
        else if (in_xfer)
        begin
            now_next = in_data.now_ms;
        end
        else if (state_reg == ST_DIV && div_rsp.done)
        begin
            missed_next            = missed_sat;
            res_next.missed_count  = missed_sat;
            res_next.event_code    = EV_NONE;
            res_next.event_time_ms = '0;
            priority if (COUNT_WIDTH'(thresh_reg) <= missed_sat)
            begin
                mode_next              = MODE_LOST;
                res_next.event_code    = EV_LOST;
                res_next.event_time_ms = now_reg;
            end
            else if (missed_sat != '0)
            begin
                mode_next = MODE_DEGRADED;
            end
            else
            begin
                // Hold the mode when no period was missed
                mode_next = mode_reg;
            end
            res_next.link_state       = mode_next;
            res_next.commands_allowed = (mode_next == MODE_CONNECTED);
        end
    end

    // Hold the output until taken
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // Configuration writes; the low address bits are ignored
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {24'd0, thresh_reg} : period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            thresh_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PERIOD)
            begin
                period_reg <= pwdata;
            end
            else
            begin
                thresh_reg <= pwdata[7:0];
            end
        end
    end

    // Control and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_WAITING;
            last_reg      <= '0;
            missed_reg    <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            last_reg      <= last_next;
            missed_reg    <= missed_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The divider only runs while the controller waits on it
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the divide state");

    // A transfer in closes the input until the result is written back
    a_stall_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input open right after a transfer");

    // A reported loss always leaves the link lost
    a_loss_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.event_code == EV_LOST |-> out_reg.link_state == MODE_LOST)
        else $error("loss event without lost state");

    // Commands are allowed exactly when connected
    a_cmd_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            out_reg.commands_allowed == (out_reg.link_state == MODE_CONNECTED))
        else $error("commands_allowed disagrees with link state");

endmodule
